// ===== src/qrm_pkg.sv =====
// Shared widths and constants for the quaternion to rotation matrix core.
// No dependencies; every other file imports this package.
package qrm_pkg;
	localparam int DATA_W    = 16;          // input and output field width
	localparam int FRAC_W    = 14;          // fractional bits, Q2.14
	localparam int PROD_W    = 2 * DATA_W;  // one 16x16 product
	localparam int N_W       = PROD_W + 1;  // norm and numerator magnitude
	localparam int NUM_W     = N_W + 2;     // signed numerator
	localparam int Q_W       = FRAC_W + 1;  // quotient bits, up to 1.0
	localparam int DIV_STEPS = Q_W;         // one quotient bit per stage
	localparam int LANE_LAT  = DIV_STEPS + 1; // division steps plus rounding
	localparam int N_ENT     = 9;

	localparam logic signed [DATA_W-1:0] ONE_FIX = DATA_W'(1 << FRAC_W);
	localparam logic signed [DATA_W-1:0] OUT_MAX = DATA_W'((1 << (DATA_W - 1)) - 1);

	typedef logic signed [DATA_W-1:0] fix_t;
endpackage

// ===== src/qrm_if.sv =====
// Valid/ready channel interfaces for quaternions in and matrices out.
// Depends on qrm_pkg for the field type.
interface qrm_quat_if;
	import qrm_pkg::*;
	logic valid;
	logic ready;
	fix_t qx, qy, qz, qw;
	modport source (output valid, qx, qy, qz, qw, input ready);
	modport sink (input valid, qx, qy, qz, qw, output ready);
endinterface

interface qrm_mat_if;
	import qrm_pkg::*;
	logic valid;
	logic ready;
	fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		output ready);
endinterface

// ===== src/qrm_div_lane.sv =====
// Pipelined restoring divider for one matrix entry: round(mag * 2^14 / den).
// Depends on qrm_pkg; one quotient bit per stage, then a rounding stage.
module qrm_div_lane import qrm_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [N_W-1:0] mag,
	input  logic [N_W-1:0] den,
	input  logic           neg,
	output fix_t           res
);
	logic [N_W-1:0] rem_s [DIV_STEPS];
	logic [N_W-1:0] den_s [DIV_STEPS];
	logic [Q_W-1:0] quo_s [DIV_STEPS];
	logic           neg_s [DIV_STEPS];
	fix_t           res_s;

	// integer bit: the magnitude never exceeds the norm
	logic [N_W:0] t0;
	logic         ge0;
	assign t0  = {1'b0, mag};
	assign ge0 = t0 >= {1'b0, den};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ge0 ? N_W'(t0 - {1'b0, den}) : mag;
			quo_s[0] <= {{(Q_W-1){1'b0}}, ge0};
			den_s[0] <= den;
			neg_s[0] <= neg;
		end
	end

	for (genvar k = 1; k < DIV_STEPS; k++) begin : g_step
		logic [N_W:0] t;
		logic         ge;
		assign t  = {rem_s[k-1], 1'b0};
		assign ge = t >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? N_W'(t - {1'b0, den_s[k-1]}) : t[N_W-1:0];
				quo_s[k] <= {quo_s[k-1][Q_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// round half away from zero: bump when twice the remainder reaches den
	logic [N_W:0]      tr;
	logic              inc;
	logic [DATA_W-1:0] qr;
	logic [DATA_W-1:0] qsat;
	assign tr   = {rem_s[DIV_STEPS-1], 1'b0};
	assign inc  = tr >= {1'b0, den_s[DIV_STEPS-1]};
	assign qr   = DATA_W'({1'b0, quo_s[DIV_STEPS-1]}) + DATA_W'(inc);
	assign qsat = qr[DATA_W-1] ? OUT_MAX : qr;

	always_ff @(posedge clk) begin
		if (en) res_s <= neg_s[DIV_STEPS-1] ? -qsat : qsat;
	end

	assign res = res_s;
endmodule

// ===== src/quaternion_to_rotation_matrix_core.sv =====
// Quaternion (Q2.14) to 3x3 rotation matrix (Q2.14), fully pipelined.
// Stages: products, norm and numerators, 15 divider bit stages, rounding.
// Throughput one transfer per cycle; a stalled output freezes the whole pipeline.
// The fifteen per-entry restoring divider stages set the depth.
// arst_n clears the valid bits only; data registers carry no reset.
// Depends on qrm_pkg, qrm_if and qrm_div_lane.
module quaternion_to_rotation_matrix_core import qrm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	qrm_quat_if.sink  quat,
	qrm_mat_if.source mat
);
	// Advance every stage whenever the output slot is free or being drained.
	logic en;
	logic vld_q [LANE_LAT];
	logic zro_q [LANE_LAT];
	assign en = !vld_q[LANE_LAT-1] || mat.ready;
	assign quat.ready = en;

	// Stage 1: the ten component products.
	logic v_s1;
	logic signed [PROD_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [PROD_W-1:0] xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= quat.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= quat.qx * quat.qx;
			yy_s1 <= quat.qy * quat.qy;
			zz_s1 <= quat.qz * quat.qz;
			ww_s1 <= quat.qw * quat.qw;
			xy_s1 <= quat.qx * quat.qy;
			xz_s1 <= quat.qx * quat.qz;
			yz_s1 <= quat.qy * quat.qz;
			wx_s1 <= quat.qw * quat.qx;
			wy_s1 <= quat.qw * quat.qy;
			wz_s1 <= quat.qw * quat.qz;
		end
	end

	// Stage 2: norm, nine signed numerators, split into sign and magnitude.
	logic signed [NUM_W-1:0] nrm;
	logic signed [NUM_W-1:0] num [N_ENT];
	logic [N_W-1:0]          nmag [N_ENT];
	logic                    nneg [N_ENT];

	function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
		return NUM_W'(p);
	endfunction

	always_comb begin
		nrm    = ext(xx_s1) + ext(yy_s1) + ext(zz_s1) + ext(ww_s1);
		num[0] = nrm - ((ext(yy_s1) + ext(zz_s1)) <<< 1);
		num[1] = (ext(xy_s1) - ext(wz_s1)) <<< 1;
		num[2] = (ext(xz_s1) + ext(wy_s1)) <<< 1;
		num[3] = (ext(xy_s1) + ext(wz_s1)) <<< 1;
		num[4] = nrm - ((ext(xx_s1) + ext(zz_s1)) <<< 1);
		num[5] = (ext(yz_s1) - ext(wx_s1)) <<< 1;
		num[6] = (ext(xz_s1) - ext(wy_s1)) <<< 1;
		num[7] = (ext(yz_s1) + ext(wx_s1)) <<< 1;
		num[8] = nrm - ((ext(xx_s1) + ext(yy_s1)) <<< 1);
		for (int i = 0; i < N_ENT; i++) begin
			nneg[i] = num[i][NUM_W-1];
			nmag[i] = nneg[i] ? N_W'(-num[i]) : N_W'(num[i]);
		end
	end

	logic           v_s2;
	logic           zro_s2;
	logic [N_W-1:0] den_s2;
	logic [N_W-1:0] mag_s2 [N_ENT];
	logic           neg_s2 [N_ENT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= N_W'(nrm);
			zro_s2 <= (nrm == '0);
			for (int i = 0; i < N_ENT; i++) begin
				mag_s2[i] <= nmag[i];
				neg_s2[i] <= nneg[i];
			end
		end
	end

	// Divider lanes; valid and zero-norm flag travel alongside.
	fix_t lres [N_ENT];
	for (genvar i = 0; i < N_ENT; i++) begin : g_lane
		qrm_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.mag (mag_s2[i]),
			.den (den_s2),
			.neg (neg_s2[i]),
			.res (lres[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LANE_LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= v_s2;
			for (int k = 1; k < LANE_LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zro_q[0] <= zro_s2;
			for (int k = 1; k < LANE_LAT; k++) zro_q[k] <= zro_q[k-1];
		end
	end

	// Zero norm: drop the divider output and force the identity.
	fix_t ent [N_ENT];
	always_comb begin
		for (int i = 0; i < N_ENT; i++) begin
			if (zro_q[LANE_LAT-1]) ent[i] = (i % 4 == 0) ? ONE_FIX : '0;
			else ent[i] = lres[i];
		end
	end

	assign mat.valid = vld_q[LANE_LAT-1];
	assign mat.m00 = ent[0];
	assign mat.m01 = ent[1];
	assign mat.m02 = ent[2];
	assign mat.m10 = ent[3];
	assign mat.m11 = ent[4];
	assign mat.m12 = ent[5];
	assign mat.m20 = ent[6];
	assign mat.m21 = ent[7];
	assign mat.m22 = ent[8];

`ifndef SYNTH
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && zro_q[LANE_LAT-1] |-> mat.m00 == ONE_FIX && mat.m11 == ONE_FIX
		&& mat.m22 == ONE_FIX && mat.m01 == '0)
		else $error("zero quaternion did not give identity");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid |-> mat.m00 <= ONE_FIX && mat.m00 >= -ONE_FIX
		&& mat.m12 <= ONE_FIX && mat.m12 >= -ONE_FIX)
		else $error("matrix entry outside [-1, 1]");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && !mat.ready |=> mat.valid && $stable(mat.m01) && $stable(mat.m22))
		else $error("stalled result changed");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!mat.valid |-> quat.ready)
		else $error("input blocked with empty output");
`endif
endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for quaternion_to_rotation_matrix_core: a table of directed quaternions,
// then random ones, with expected matrices worked out by an exact fixed point predictor.
// Depends on qrm_pkg, qrm_if and the core RTL.
module tb_top;
	import qrm_pkg::*;

	localparam int RAND_ITEMS = 450;
	localparam int MAX_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		fix_t qx, qy, qz, qw;
	} quat_t;

	typedef struct packed {
		fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	} mat_t;

	// Directed row: the quaternion, and a typed-in matrix where it is obvious.
	typedef struct {
		quat_t q;
		bit    known;
		mat_t  m;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qrm_quat_if quat();
	qrm_mat_if  mat();

	quaternion_to_rotation_matrix_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat.sink),
		.mat    (mat.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	mat_t      pending_mats[$];
	int        error_count = 0;
	longint    cycle_count = 0;
	bit        stim_done = 1'b0;
	bit        hold_req = 1'b0;    // asks for the long receiver hold-off
	bit        rx_hold = 1'b0;     // long receiver hold-off, set by its own process
	bit        calm = 1'b0;        // no random idling on either side
	stim_row_t dir_rows[$];

	function automatic stim_row_t mk_row(int x, int y, int z, int w);
		stim_row_t r;
		r.q = '{fix_t'(x), fix_t'(y), fix_t'(z), fix_t'(w)};
		r.known = 1'b0;
		r.m = '0;
		return r;
	endfunction

	function automatic mat_t ident_mat();
		return '{ONE_FIX, 16'sd0, 16'sd0, 16'sd0, ONE_FIX, 16'sd0, 16'sd0, 16'sd0, ONE_FIX};
	endfunction

	// round(num * 2^14 / n), ties away from zero, then clamp to 16 bits
	function automatic fix_t round_entry(longint num, longint n);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = ((mag <<< (FRAC_W + 1)) + n) / (n <<< 1);
		if (num < 0)
			q = -q;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return fix_t'(q);
	endfunction

	function automatic mat_t rotation_of(quat_t q);
		longint x, y, z, w, xx, yy, zz, n;
		mat_t m;
		x = q.qx; y = q.qy; z = q.qz; w = q.qw;
		xx = x * x; yy = y * y; zz = z * z;
		n = xx + yy + zz + w * w;
		if (n == 0)
			return ident_mat();
		m.m00 = round_entry(n - 2 * (yy + zz), n);
		m.m01 = round_entry(2 * (x * y - w * z), n);
		m.m02 = round_entry(2 * (x * z + w * y), n);
		m.m10 = round_entry(2 * (x * y + w * z), n);
		m.m11 = round_entry(n - 2 * (xx + zz), n);
		m.m12 = round_entry(2 * (y * z - w * x), n);
		m.m20 = round_entry(2 * (x * z - w * y), n);
		m.m21 = round_entry(2 * (y * z + w * x), n);
		m.m22 = round_entry(n - 2 * (xx + yy), n);
		return m;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("[%0d] mismatch %s: got %0d expected %0d", cycle_count, what, got, want);
		error_count++;
	endtask

	function automatic quat_t rand_quat();
		quat_t q;
		int mode;
		mode = $urandom_range(0, 9);
		q = quat_t'({$urandom, $urandom});
		// keep some components small so near-axis and mixed-scale cases show up
		if (mode < 3) begin
			q.qx = fix_t'($urandom_range(0, 64)) - 16'sd32;
			q.qz = fix_t'($urandom_range(0, 8)) - 16'sd4;
		end else if (mode == 3) begin
			q = '{16'sd0, 16'sd0, 16'sd0, fix_t'($urandom_range(0, 3)) - 16'sd1};
		end
		return q;
	endfunction

	initial begin
		stim_row_t r;
		r = mk_row(0, 0, 0, 0);           r.known = 1; r.m = ident_mat(); dir_rows.push_back(r);
		r = mk_row(0, 0, 0, 16384);       r.known = 1; r.m = ident_mat(); dir_rows.push_back(r);
		r = mk_row(0, 0, 0, -16384);      r.known = 1; r.m = ident_mat(); dir_rows.push_back(r);
		r = mk_row(0, 0, 0, 1);           r.known = 1; r.m = ident_mat(); dir_rows.push_back(r);
		r = mk_row(0, 0, 0, -32768);      r.known = 1; r.m = ident_mat(); dir_rows.push_back(r);
		// half turn about x: diag(1,-1,-1)
		r = mk_row(16384, 0, 0, 0);       r.known = 1;
		r.m = '{ONE_FIX, 16'sd0, 16'sd0, 16'sd0, -ONE_FIX, 16'sd0, 16'sd0, 16'sd0, -ONE_FIX};
		dir_rows.push_back(r);
		dir_rows.push_back(mk_row(0, 16384, 0, 0));
		dir_rows.push_back(mk_row(0, 0, 16384, 0));
		dir_rows.push_back(mk_row(32767, 32767, 32767, 32767));
		dir_rows.push_back(mk_row(-32768, -32768, -32768, -32768));
		dir_rows.push_back(mk_row(-32768, 32767, -32768, 32767));
		dir_rows.push_back(mk_row(32767, -32768, 0, 1));
		dir_rows.push_back(mk_row(1, 1, 1, 1));
		dir_rows.push_back(mk_row(-1, 0, 0, 0));
		dir_rows.push_back(mk_row(1, -1, 0, 0));
		dir_rows.push_back(mk_row(11585, 0, 0, 11585));
		dir_rows.push_back(mk_row(0, -11585, 0, 11585));
		dir_rows.push_back(mk_row(0, 0, 11585, -11585));
		dir_rows.push_back(mk_row(8192, 8192, 8192, 8192));
		dir_rows.push_back(mk_row(-21846, 5461, 3, -7));
		dir_rows.push_back(mk_row(3, 5, 7, 11));
	end

	// Hold reset from time zero, then release it once.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Offer one quaternion and hold it until the transfer happens.
	task automatic send_quat(quat_t q);
		while (!calm && $urandom_range(0, 99) < 24) begin
			quat.valid <= 1'b0;
			@(posedge clk);
		end
		quat.valid <= 1'b1;
		{quat.qx, quat.qy, quat.qz, quat.qw} <= q;
		@(posedge clk);
		while (!quat.ready)
			@(posedge clk);
		// prediction follows the transfer, not the offer
		pending_mats.push_back(rotation_of(q));
	endtask

	// Directed table first: typed-in rows are checked against the predictor too,
	// so a wrong predictor fails loudly rather than masking the block.
	initial begin
		mat_t m;
		quat.valid <= 1'b0;
		{quat.qx, quat.qy, quat.qz, quat.qw} <= '0;
		@(posedge clk iff arst_n);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].known) begin
				m = rotation_of(dir_rows[i].q);
				if (m != dir_rows[i].m)
					report_mismatch($sformatf("table row %0d", i), 0, 1);
			end
			send_quat(dir_rows[i].q);
		end
		for (int i = 0; i < RAND_ITEMS; i++) begin
			calm = (i >= 150 && i < 230);
			// stall the output for a long stretch while input keeps coming
			if (i == 300)
				hold_req = 1'b1;
			send_quat(rand_quat());
		end
		quat.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver hold-off: count its own cycles, then release.
	initial begin
		wait (hold_req);
		rx_hold = 1'b1;
		repeat (120) @(posedge clk);
		rx_hold = 1'b0;
	end

	// Drive ready at the edge, with random stalls.
	always @(posedge clk) begin
		if (!arst_n)
			mat.ready <= 1'b0;
		else
			mat.ready <= !rx_hold && (calm || $urandom_range(0, 99) >= 24);
	end

	// Compare each transfer with the oldest expected matrix, field by field.
	always @(posedge clk) begin
		mat_t want;
		if (arst_n && mat.valid && mat.ready) begin
			if (pending_mats.size() == 0) begin
				report_mismatch("unexpected matrix", 1, 0);
			end else begin
				want = pending_mats.pop_front();
				if (mat.m00 !== want.m00) report_mismatch("m00", mat.m00, want.m00);
				if (mat.m01 !== want.m01) report_mismatch("m01", mat.m01, want.m01);
				if (mat.m02 !== want.m02) report_mismatch("m02", mat.m02, want.m02);
				if (mat.m10 !== want.m10) report_mismatch("m10", mat.m10, want.m10);
				if (mat.m11 !== want.m11) report_mismatch("m11", mat.m11, want.m11);
				if (mat.m12 !== want.m12) report_mismatch("m12", mat.m12, want.m12);
				if (mat.m20 !== want.m20) report_mismatch("m20", mat.m20, want.m20);
				if (mat.m21 !== want.m21) report_mismatch("m21", mat.m21, want.m21);
				if (mat.m22 !== want.m22) report_mismatch("m22", mat.m22, want.m22);
			end
		end
	end

	// End of run: drain, settle, then give the verdict; a timeout fails outright.
	initial begin
		fork
			begin
				wait (stim_done);
				while (pending_mats.size() != 0)
					@(posedge clk);
				repeat (DRAIN_CYCLES) @(posedge clk);
			end
			begin
				wait (cycle_count >= MAX_CYCLES);
				$display("timeout with %0d matrices outstanding", pending_mats.size());
				error_count++;
			end
		join_any
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== sim.f =====
src/qrm_pkg.sv
src/qrm_if.sv
src/qrm_div_lane.sv
src/quaternion_to_rotation_matrix_core.sv
dv/tb_top.sv
